/* rtl/esc_pkg.sv */
package esc_pkg;

    localparam int ANGLE_BITS = 32;
    localparam int COUNT_BITS = 12;

    localparam int TORQUE_BITS = 16;
    localparam int LIMIT_BITS  = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [TORQUE_BITS-1:0] SEEK_TORQUE_RST = TORQUE_BITS'(200);
    localparam logic [LIMIT_BITS-1:0]  ANGLE_LIMIT_RST = LIMIT_BITS'(100);
    localparam logic [LIMIT_BITS-1:0]  TICK_LIMIT_RST  = LIMIT_BITS'(100);

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_ABORT = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CCW  = 2'd1,
        PH_CW   = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_HOLD  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        LOCK_NONE = 2'd0,
        LOCK_CCW  = 2'd1,
        LOCK_CW   = 2'd2
    } t_lock;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SEEK_TORQUE = 2'd0,
        CFG_ANGLE_LIMIT = 2'd1,
        CFG_TICK_LIMIT  = 2'd2
    } t_cfg_idx;

    localparam logic DIR_CCW = 1'b0;
    localparam logic DIR_CW  = 1'b1;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [ANGLE_BITS-1:0] sample_angle;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                   drive_mode;
        logic                         drive_dir;
        logic [TORQUE_BITS-1:0]       drive_torque;
        logic [1:0]                   phase;
        logic [1:0]                   lock_event;
        logic signed [ANGLE_BITS-1:0] lock_angle;
        logic                         zero_set;
    } t_out_word;

    typedef struct packed {
        logic [TORQUE_BITS-1:0] seek_torque;
        logic [LIMIT_BITS-1:0]  stall_angle_limit;
        logic [LIMIT_BITS-1:0]  stall_tick_limit;
    } t_cfg;

endpackage

/* rtl/esc_cfg.sv */
module esc_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [esc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [esc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output esc_pkg::t_cfg                        o_cfg
);

    esc_pkg::t_cfg r_cfg;
    esc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (esc_pkg::t_cfg_idx'(i_cfg_index))
                esc_pkg::CFG_SEEK_TORQUE: begin
                    n_cfg.seek_torque = i_cfg_data[esc_pkg::TORQUE_BITS-1:0];
                end
                esc_pkg::CFG_ANGLE_LIMIT: begin
                    n_cfg.stall_angle_limit = i_cfg_data[esc_pkg::LIMIT_BITS-1:0];
                end
                esc_pkg::CFG_TICK_LIMIT: begin
                    n_cfg.stall_tick_limit = i_cfg_data[esc_pkg::LIMIT_BITS-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seek_torque       <= esc_pkg::SEEK_TORQUE_RST;
            r_cfg.stall_angle_limit <= esc_pkg::ANGLE_LIMIT_RST;
            r_cfg.stall_tick_limit  <= esc_pkg::TICK_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/esc_core.sv */
module esc_core #(
    parameter int COUNT_BITS = esc_pkg::COUNT_BITS
) (
    input  esc_pkg::t_in_word                      i_word,
    input  esc_pkg::t_cfg                          i_cfg,
    input  esc_pkg::t_phase                        i_phase,
    input  logic signed [esc_pkg::ANGLE_BITS-1:0]  i_prev,
    input  logic [COUNT_BITS-1:0]                  i_count,
    output esc_pkg::t_phase                        o_phase,
    output logic signed [esc_pkg::ANGLE_BITS-1:0]  o_prev,
    output logic [COUNT_BITS-1:0]                  o_count,
    output esc_pkg::t_out_word                     o_word
);

    localparam int CMP_W = (COUNT_BITS > esc_pkg::LIMIT_BITS) ? COUNT_BITS
                                                              : esc_pkg::LIMIT_BITS;
    localparam int DIFF_W = esc_pkg::ANGLE_BITS + 1;

    logic signed [DIFF_W-1:0] step_diff;
    logic [DIFF_W-1:0]        step_abs;
    logic                     stalled;
    logic [COUNT_BITS-1:0]    count_inc;
    logic [COUNT_BITS-1:0]    count_upd;
    logic [CMP_W-1:0]         count_cmp;
    logic [CMP_W-1:0]         limit_cmp;
    logic                     locked;
    esc_pkg::t_phase          phase_cmd;

    // exact angle step, one bit wider so it cannot wrap
    assign step_diff = DIFF_W'(i_word.sample_angle) - DIFF_W'(i_prev);
    assign step_abs  = step_diff[DIFF_W-1] ? DIFF_W'(-step_diff) : DIFF_W'(step_diff);
    assign stalled   = step_abs < DIFF_W'(i_cfg.stall_angle_limit);

    // saturate at all ones
    assign count_inc = (&i_count) ? i_count : i_count + COUNT_BITS'(1);
    assign count_upd = stalled ? count_inc : '0;
    assign count_cmp = CMP_W'(count_upd);
    assign limit_cmp = CMP_W'(i_cfg.stall_tick_limit);
    assign locked    = count_cmp > limit_cmp;

    always_comb begin
        o_phase   = i_phase;
        o_prev    = i_prev;
        o_count   = i_count;
        phase_cmd = i_phase;
        o_word    = '0;

        unique case (esc_pkg::t_func'(i_word.func))
            esc_pkg::FUNC_TICK: begin
                unique case (i_phase)
                    esc_pkg::PH_IDLE: begin
                        o_word.drive_mode = esc_pkg::MODE_OFF;
                    end
                    esc_pkg::PH_DONE: begin
                        o_word.drive_mode = esc_pkg::MODE_HOLD;
                        o_word.zero_set   = 1'b1;
                        o_prev            = i_word.sample_angle;
                    end
                    esc_pkg::PH_CCW, esc_pkg::PH_CW: begin
                        o_prev            = i_word.sample_angle;
                        o_word.drive_mode = esc_pkg::MODE_DRIVE;
                        if (locked) begin
                            o_count             = '0;
                            o_word.drive_dir    = esc_pkg::DIR_CW;
                            o_word.drive_torque = '0;
                            o_word.lock_angle   = i_word.sample_angle;
                            if (i_phase == esc_pkg::PH_CCW) begin
                                o_word.lock_event = esc_pkg::LOCK_CCW;
                                o_phase           = esc_pkg::PH_CW;
                            end else begin
                                o_word.lock_event = esc_pkg::LOCK_CW;
                                o_phase           = esc_pkg::PH_DONE;
                            end
                        end else begin
                            o_count             = count_upd;
                            o_word.drive_dir    = (i_phase == esc_pkg::PH_CW) ?
                                                  esc_pkg::DIR_CW : esc_pkg::DIR_CCW;
                            o_word.drive_torque = i_cfg.seek_torque;
                        end
                    end
                    default: begin
                        o_phase = i_phase;
                    end
                endcase
            end
            esc_pkg::FUNC_START, esc_pkg::FUNC_ABORT, esc_pkg::FUNC_NOP: begin
                if (esc_pkg::t_func'(i_word.func) == esc_pkg::FUNC_START &&
                    (i_phase == esc_pkg::PH_IDLE || i_phase == esc_pkg::PH_DONE)) begin
                    phase_cmd = esc_pkg::PH_CCW;
                    o_prev    = '0;
                    o_count   = '0;
                end else if (esc_pkg::t_func'(i_word.func) == esc_pkg::FUNC_ABORT) begin
                    phase_cmd = esc_pkg::PH_IDLE;
                end
                o_phase = phase_cmd;
                // report the standing drive of the resulting phase
                unique case (phase_cmd)
                    esc_pkg::PH_CCW, esc_pkg::PH_CW: begin
                        o_word.drive_mode   = esc_pkg::MODE_DRIVE;
                        o_word.drive_dir    = (phase_cmd == esc_pkg::PH_CW) ?
                                              esc_pkg::DIR_CW : esc_pkg::DIR_CCW;
                        o_word.drive_torque = i_cfg.seek_torque;
                    end
                    esc_pkg::PH_DONE: begin
                        o_word.drive_mode = esc_pkg::MODE_HOLD;
                    end
                    default: begin
                        o_word.drive_mode = esc_pkg::MODE_OFF;
                    end
                endcase
            end
            default: begin
                o_phase = i_phase;
            end
        endcase

        o_word.phase = o_phase;
    end

endmodule

/* rtl/end_stop_stall_calibrator.sv */
// Data path: a word accepted at the input lands in the input register and then
// moves on into the result register; it waits in a register only while the
// output stalls.
// Throughput: one word per cycle while the output does not stall; the stall test
// and counter update for the step sit in esc_core between the input and result registers.
// Reset (i_rst_n low at a clock edge): idle phase, previous angle and stall
// count zero, configuration back to torque 200 and both limits 100, pipe empty.
module end_stop_stall_calibrator #(
    parameter int COUNT_BITS = esc_pkg::COUNT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  esc_pkg::t_in_word                 i_in_word,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output esc_pkg::t_out_word                o_out_word,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [esc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [esc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    // Input stage
    logic                                  r_in_valid;
    esc_pkg::t_in_word                     r_in_word;

    // Calibration state
    esc_pkg::t_phase                       r_phase;
    logic signed [esc_pkg::ANGLE_BITS-1:0] r_prev;
    logic [COUNT_BITS-1:0]                 r_count;

    // Result stage
    logic                                  r_out_valid;
    esc_pkg::t_out_word                    r_out_word;

    esc_pkg::t_phase                       n_phase;
    logic signed [esc_pkg::ANGLE_BITS-1:0] n_prev;
    logic [COUNT_BITS-1:0]                 n_count;
    esc_pkg::t_out_word                    n_out_word;

    esc_pkg::t_cfg                         cfg;
    logic                                  advance;
    logic                                  in_take;
    logic                                  step_fire;

    // Config writes are taken every cycle; software must write only while idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    esc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    esc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_word  (r_in_word),
        .i_cfg   (cfg),
        .i_phase (r_phase),
        .i_prev  (r_prev),
        .i_count (r_count),
        .o_phase (n_phase),
        .o_prev  (n_prev),
        .o_count (n_count),
        .o_word  (n_out_word)
    );

    // The pipe moves whenever the result register is empty or being drained.
    assign advance   = !r_out_valid || !i_out_stall;
    // Refill the input register when it is empty or moves on this cycle.
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    // State commits only when a held word actually moves into the result stage.
    assign step_fire  = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= esc_pkg::PH_IDLE;
            r_prev      <= '0;
            r_count     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step_fire) begin
                r_phase <= n_phase;
                r_prev  <= n_prev;
                r_count <= n_count;
            end
        end
    end

    // Payload registers: load on the same handshakes, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (step_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
